[design/salj_pkg.sv]
// Shared constants for the salinity jump and range alarm block.
package salj_pkg;

	// Delay line depth and sample width
	localparam int LAG         = 12;
	localparam int SAMPLE_BITS = 16;
	localparam int FILL_BITS   = $clog2(LAG + 1);

	// Configuration register widths
	localparam int LIMIT_BITS = 16;
	localparam int BLEN_BITS  = 12;
	localparam int CFG_BITS   = 16;
	localparam int IDX_BITS   = 2;

	// Configuration register indexes
	localparam logic [IDX_BITS-1:0] CFG_JUMP_LIMIT  = 2'd0;
	localparam logic [IDX_BITS-1:0] CFG_RANGE_LIMIT = 2'd1;
	localparam logic [IDX_BITS-1:0] CFG_BLOCK_LEN   = 2'd2;

	// Register reset values
	localparam logic [LIMIT_BITS-1:0] JUMP_LIMIT_RST  = 16'd200;
	localparam logic [LIMIT_BITS-1:0] RANGE_LIMIT_RST = 16'd500;
	localparam logic [BLEN_BITS-1:0]  BLOCK_LEN_RST   = 12'd288;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

endpackage

[design/salinity_jump_and_range_alarm.sv]
// Salinity lagged-jump and block-range alarm, top level.
// Throughput: one request per cycle while out_stall does not hold a full result register.
// An input register and a result register carry the work: an accepted request waits in the first, then moves on.
// The input side stalls only while the input register is full and the result is stalled.
// Reset (arst_n low, asynchronous): limits 200/500, block length 288, delay line empty,
// block tracking cleared, both stages empty.
module salinity_jump_and_range_alarm (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] salinity,
	input  logic        sample_valid,
	input  logic        last_sample,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        jump_alarm,
	output logic [15:0] jump_size,
	output logic        block_closed,
	output logic        range_alarm,
	output logic [15:0] block_range
);

	// configuration registers
	logic [salj_pkg::LIMIT_BITS-1:0] jump_limit_q;
	logic [salj_pkg::LIMIT_BITS-1:0] range_limit_q;
	logic [salj_pkg::BLEN_BITS-1:0]  block_len_q;

	// input stage
	logic              valid_s1;
	salj_pkg::sample_t sample_s1;
	logic              smp_valid_s1;
	logic              last_s1;

	// delay line and block tracking state
	salj_pkg::sample_t               lag_value_q [salj_pkg::LAG];
	logic [salj_pkg::LAG-1:0]        lag_valid_q;
	logic [salj_pkg::FILL_BITS-1:0]  fill_q;
	logic [salj_pkg::BLEN_BITS-1:0]  pos_q;
	salj_pkg::sample_t               min_q;
	salj_pkg::sample_t               max_q;
	logic                            has_valid_q;

	// result register
	logic        out_valid_q;
	logic        jump_alarm_q;
	logic [15:0] jump_size_q;
	logic        block_closed_q;
	logic        range_alarm_q;
	logic [15:0] block_range_q;

	// handshake
	logic in_take;
	logic advance;

	// combinational results of the item in the input stage
	salj_pkg::sample_t              old_value;
	salj_pkg::sample_t              diff;
	logic                           jump_chk;
	logic                           jump_hit;
	salj_pkg::sample_t              min_nxt;
	salj_pkg::sample_t              max_nxt;
	logic                           has_valid_nxt;
	logic [salj_pkg::BLEN_BITS-1:0] pos_nxt;
	logic [salj_pkg::BLEN_BITS-1:0] need;
	logic                           closed;
	salj_pkg::sample_t              range_val;

	// advance the input stage when the result register is free or drains
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// jump check against the oldest delay line entry
	always_comb begin
		old_value = lag_value_q[salj_pkg::LAG-1];
		diff      = (sample_s1 >= old_value) ? (sample_s1 - old_value) : (old_value - sample_s1);
		jump_chk  = (fill_q == salj_pkg::FILL_BITS'(salj_pkg::LAG)) && smp_valid_s1
			&& lag_valid_q[salj_pkg::LAG-1];
		jump_hit  = jump_chk && (16'(diff) > jump_limit_q);
	end

	// block min/max, position and close decision
	always_comb begin
		min_nxt       = min_q;
		max_nxt       = max_q;
		has_valid_nxt = has_valid_q;
		if (smp_valid_s1) begin
			if (sample_s1 < min_q)
				min_nxt = sample_s1;
			if (sample_s1 > max_q)
				max_nxt = sample_s1;
			has_valid_nxt = 1'b1;
		end
		pos_nxt   = pos_q + 1'b1;
		need      = (block_len_q == '0) ? salj_pkg::BLEN_BITS'(1) : block_len_q;
		closed    = (pos_nxt >= need) || (pos_nxt == '0) || last_s1;
		range_val = has_valid_nxt ? (max_nxt - min_nxt) : '0;
	end

	// write configuration registers; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q  <= salj_pkg::JUMP_LIMIT_RST;
			range_limit_q <= salj_pkg::RANGE_LIMIT_RST;
			block_len_q   <= salj_pkg::BLOCK_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				salj_pkg::CFG_JUMP_LIMIT:  jump_limit_q  <= cfg_data;
				salj_pkg::CFG_RANGE_LIMIT: range_limit_q <= cfg_data;
				salj_pkg::CFG_BLOCK_LEN:   block_len_q   <= cfg_data[salj_pkg::BLEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the request payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1    <= salinity;
			smp_valid_s1 <= sample_valid;
			last_s1      <= last_sample;
		end
	end

	// shift the delay line values; validity gates their use
	always_ff @(posedge clk) begin
		if (advance) begin
			lag_value_q[0] <= sample_s1;
			for (int i = 1; i < salj_pkg::LAG; i++)
				lag_value_q[i] <= lag_value_q[i-1];
		end
	end

	// delay line valid bits and fill count; drop all on end of data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lag_valid_q <= '0;
			fill_q      <= '0;
		end else if (advance) begin
			if (last_s1) begin
				lag_valid_q <= '0;
				fill_q      <= '0;
			end else begin
				lag_valid_q <= {lag_valid_q[salj_pkg::LAG-2:0], smp_valid_s1};
				if (fill_q != salj_pkg::FILL_BITS'(salj_pkg::LAG))
					fill_q <= fill_q + 1'b1;
			end
		end
	end

	// block tracking; restart on close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			has_valid_q <= 1'b0;
		end else if (advance) begin
			if (closed) begin
				pos_q       <= '0;
				min_q       <= '1;
				max_q       <= '0;
				has_valid_q <= 1'b0;
			end else begin
				pos_q       <= pos_nxt;
				min_q       <= min_nxt;
				max_q       <= max_nxt;
				has_valid_q <= has_valid_nxt;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			jump_alarm_q   <= jump_hit;
			jump_size_q    <= jump_chk ? 16'(diff) : 16'd0;
			block_closed_q <= closed;
			range_alarm_q  <= closed && (16'(range_val) > range_limit_q);
			block_range_q  <= closed ? 16'(range_val) : 16'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign jump_alarm   = jump_alarm_q;
	assign jump_size    = jump_size_q;
	assign block_closed = block_closed_q;
	assign range_alarm  = range_alarm_q;
	assign block_range  = block_range_q;

endmodule
